// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top level of the range outlier trigger.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that implies another in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that implies another in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rote_pkg.sv =====
// Types and constants of the range outlier trigger.
`default_nettype none

package rote_pkg;

    localparam int DIST_W   = 17;
    localparam int AVG_W    = 24;
    localparam int DELTA_W  = 24;
    localparam int ALPHA_W  = 17;
    localparam int THR_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int FRAC_W   = 8;   // fraction bits of the Q16.8 average
    localparam int ALPHA_FRAC_W = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
    localparam logic [THR_W-1:0]   THR_RESET = 8'd1;

    // Product of the 24-bit average and the 17-bit weight, and the sum of two.
    localparam int PROD_W = AVG_W + ALPHA_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DELTA       = 2'd0,
        CFG_DECAY_ALPHA     = 2'd1,
        CFG_RESET_THRESHOLD = 2'd2
    } t_cfg_idx;

    // Effective configuration seen by the datapath.
    typedef struct packed {
        logic [DELTA_W-1:0] max_delta;
        logic [ALPHA_W-1:0] alpha;      // clamped to one
        logic [THR_W-1:0]   threshold;  // zero reads as one
    } t_cfg;

    // Reload of the trigger run counter on a threshold write.
    typedef struct packed {
        logic             load;
        logic [THR_W-1:0] value;
    } t_run_load;

    typedef struct packed {
        logic             trigger;
        logic [AVG_W-1:0] average_distance;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/rote_in_if.sv =====
// Input channel carrying one distance sample per transaction.
`default_nettype none

interface rote_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [rote_pkg::DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rote_out_if.sv =====
// Output channel carrying the trigger flag and the moving average.
`default_nettype none

interface rote_out_if;
    logic                        valid;
    logic                        ready;
    logic                        trigger;
    logic [rote_pkg::AVG_W-1:0]  average_distance;

    modport source (output valid, output trigger, output average_distance, input ready);
    modport sink   (input valid, input trigger, input average_distance, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rote_cfg.sv =====
// Configuration registers of the range outlier trigger.
`default_nettype none

module rote_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rote_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [rote_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output rote_pkg::t_cfg                         o_cfg,
    output rote_pkg::t_run_load                    o_run_load
);

    logic [rote_pkg::DELTA_W-1:0] r_max_delta;
    logic [rote_pkg::ALPHA_W-1:0] r_alpha;
    logic [rote_pkg::THR_W-1:0]   r_thr;
    logic [rote_pkg::THR_W-1:0]   wr_thr;

    assign wr_thr = i_cfg_data[rote_pkg::THR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_delta <= '0;
            r_alpha     <= '0;
            r_thr       <= rote_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (rote_pkg::t_cfg_idx'(i_cfg_idx))
                rote_pkg::CFG_MAX_DELTA: begin
                    r_max_delta <= i_cfg_data[rote_pkg::DELTA_W-1:0];
                end
                rote_pkg::CFG_DECAY_ALPHA: begin
                    r_alpha <= i_cfg_data[rote_pkg::ALPHA_W-1:0];
                end
                rote_pkg::CFG_RESET_THRESHOLD: begin
                    r_thr <= wr_thr;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_cfg.max_delta = r_max_delta;
        o_cfg.alpha     = (r_alpha > rote_pkg::ALPHA_ONE) ? rote_pkg::ALPHA_ONE : r_alpha;
        o_cfg.threshold = (r_thr == '0) ? rote_pkg::THR_RESET : r_thr;

        // A threshold write also restarts the run counter at the new threshold.
        o_run_load.load  = i_cfg_we &&
                           (rote_pkg::t_cfg_idx'(i_cfg_idx) == rote_pkg::CFG_RESET_THRESHOLD);
        o_run_load.value = (wr_thr == '0) ? rote_pkg::THR_RESET : wr_thr;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rote_core.sv =====
// Filter state and combinational update datapath of the range outlier trigger.
`default_nettype none

module rote_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire rote_pkg::t_cfg                    i_cfg,
    input  wire rote_pkg::t_run_load               i_run_load,
    input  wire logic                              i_fire,
    input  wire logic [rote_pkg::DIST_W-1:0]       i_distance,
    output rote_pkg::t_result                      o_result
);

    logic [rote_pkg::AVG_W-1:0]   r_avg;
    logic [rote_pkg::AVG_W-1:0]   n_avg;
    logic [rote_pkg::THR_W-1:0]   r_run;
    logic [rote_pkg::THR_W-1:0]   n_run;

    logic                         missing;
    logic                         reload;
    logic [rote_pkg::AVG_W-1:0]   sample;
    logic [rote_pkg::ALPHA_W-1:0] alpha_inv;
    logic [rote_pkg::PROD_W-1:0]  prod_old;
    logic [rote_pkg::PROD_W-1:0]  prod_new;
    logic [rote_pkg::ACC_W-1:0]   acc;
    logic [rote_pkg::AVG_W-1:0]   filt;
    logic [rote_pkg::AVG_W-1:0]   delta;
    logic                         trig;
    logic [rote_pkg::THR_W-1:0]   run_base;

    // Any negative sample counts as a missing echo.
    assign missing = i_distance[rote_pkg::DIST_W-1];
    assign sample  = {i_distance[rote_pkg::DIST_W-2:0], rote_pkg::FRAC_W'(0)};
    assign reload  = (r_run == i_cfg.threshold);

    // Weighted sum of old average and new sample, rounded half up.
    assign alpha_inv = rote_pkg::ALPHA_ONE - i_cfg.alpha;
    assign prod_old  = rote_pkg::PROD_W'(r_avg) * rote_pkg::PROD_W'(i_cfg.alpha);
    assign prod_new  = rote_pkg::PROD_W'(sample) * rote_pkg::PROD_W'(alpha_inv);
    assign acc       = rote_pkg::ACC_W'(prod_old) + rote_pkg::ACC_W'(prod_new)
                     + rote_pkg::ROUND_HALF;
    assign filt      = acc[rote_pkg::ALPHA_FRAC_W +: rote_pkg::AVG_W];
    assign delta     = (filt >= sample) ? (filt - sample) : (sample - filt);

    always_comb begin
        priority if (missing) begin
            trig  = 1'b1;
            n_avg = r_avg;
        end else if (reload) begin
            trig  = 1'b1;
            n_avg = sample;
        end else begin
            trig  = (delta > i_cfg.max_delta);
            n_avg = filt;
        end

        // After a reload the counter restarts from zero before counting.
        run_base = (!missing && reload) ? '0 : r_run;
        if (!trig) begin
            n_run = '0;
        end else if (run_base >= i_cfg.threshold) begin
            n_run = i_cfg.threshold;
        end else begin
            n_run = run_base + rote_pkg::THR_W'(1);
        end

        o_result.trigger          = trig;
        o_result.average_distance = n_avg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg <= '0;
            r_run <= rote_pkg::THR_RESET;
        end else if (i_run_load.load) begin
            r_run <= i_run_load.value;
        end else if (i_fire) begin
            r_avg <= n_avg;
            r_run <= n_run;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/range_outlier_trigger_ema_unit.sv =====
// Top level of the range outlier trigger with exponential moving average.
// The unit takes one distance sample per input transaction and returns one result
// transaction per sample: a trigger flag and the Q16.8 moving average after that
// sample. A negative sample is a missing echo; it always triggers and leaves the
// average alone. When the count of consecutive triggers has reached the reset
// threshold, the next valid sample replaces the average and triggers. Otherwise the
// average is blended as alpha*avg + (1-alpha)*sample (alpha in Q1.16, rounded half
// up) and the unit triggers when the blended average is more than max_delta away
// from the sample. Throughput is one transaction per clock while the output is not
// stalled: a sample lands in the input register on the edge it is accepted, and the
// whole filter update (two multipliers of 24 by 17 bits, an adder and a compare)
// runs from that register into the result register and the filter state at the
// edge on which the sample is processed. The result register frees the input side,
// so a new sample is taken while a finished result waits, and the input register
// only holds when the result register is full and stalled. Configuration writes
// take effect at once; writing the reset threshold also restarts the trigger count
// at that threshold so the next valid sample reloads.
// Write configuration only while no transaction is in flight.
`default_nettype none

`include "assert_macros.svh"

module range_outlier_trigger_ema_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rote_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [rote_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    rote_in_if.sink                                i_in,
    rote_out_if.source                             o_out
);

    rote_pkg::t_cfg      cfg;
    rote_pkg::t_run_load run_load;
    rote_pkg::t_result   core_result;

    // Input register.
    logic                          r_in_valid;
    logic [rote_pkg::DIST_W-1:0]   r_in_dist;

    // Result register.
    logic                          r_out_valid;
    rote_pkg::t_result             r_out_res;

    logic                          out_free;
    logic                          fire;
    logic                          in_take;

    // The result register can be loaded when empty or being drained this cycle.
    assign out_free = !r_out_valid || o_out.ready;
    // The held sample is processed whenever its result has somewhere to go.
    assign fire     = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || fire;
    assign in_take  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_dist <= i_in.distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_res <= core_result;
        end
    end

    rote_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_run_load (run_load)
    );

    rote_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_run_load (run_load),
        .i_fire     (fire),
        .i_distance (r_in_dist),
        .o_result   (core_result)
    );

    assign o_out.valid            = r_out_valid;
    assign o_out.trigger          = r_out_res.trigger;
    assign o_out.average_distance = r_out_res.average_distance;

    // A processed sample always leaves a result waiting in the output register.
    `ASSERT_NEXT(a_fire_fills_out, i_clk, i_rst_n, fire, r_out_valid,
        "processed sample did not produce a result")

    // A missing echo must come out as a trigger.
    `ASSERT_NEXT(a_missing_triggers, i_clk, i_rst_n,
        fire && r_in_dist[rote_pkg::DIST_W-1], r_out_res.trigger,
        "missing echo did not trigger")

    // A pending result only changes when a new sample is processed.
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && !fire,
        $stable(r_out_res), "pending result changed without a new sample")

endmodule

`default_nettype wire
